>>> hdl/lkoc_pkg.sv
// Shared types and constants for the keyed object cache.
// Used by every module of the block except lkoc_ram; depends on nothing.
package lkoc_pkg;

    // Field widths of the stream items
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 4;
    localparam int STAMP_W  = 32;
    localparam int ACTIVE_W = 5;

    // Default geometry and reset value of the active entry register
    localparam int ENTRIES_DEF = 16;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd10;
    localparam logic [STAMP_W-1:0]  STAMP_MAX    = 32'hFFFF_FFFF;

    // Operation codes carried in s_tuser
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } lkoc_op_t;

    // One request as it travels from the front queue to the engine
    typedef struct packed {
        lkoc_op_t              func;
        logic [KEY_W-1:0]      key;
        logic [HANDLE_W-1:0]   handle;
    } lkoc_item_t;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } lkoc_state_t;

endpackage

>>> hdl/lru_keyed_object_cache.sv
// Sequence per item: an append or a lookup on an empty cache goes from idle straight to
// write-back; a lookup scans entries until a hit or the fill count, a replacement scans the
// clamped active_entries and picks the lowest stamp; write-back then loads m_tvalid.
// Throughput: one item in the engine at a time, taken only when the result register is free;
// one entry compared per cycle through the shared read address of the entry RAMs, then a write-back.
// Reset: queue, sequencer, fill count, access counter and output valid clear; entry RAMs
// are not cleared and no entry at or above the fill count is ever evaluated.
module lru_keyed_object_cache #(
    parameter int ENTRIES = lkoc_pkg::ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [95:0]                       s_tdata,  // lookup_key[63:0], payload_handle[95:64]
    input  logic [0:0]                        s_tuser,  // func[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,  // found_handle[31:0], slot[35:32], zero
    output logic [1:0]                        m_tuser,  // hit[0], evicted[1]
    input  logic                              cfg_we,
    input  logic [lkoc_pkg::ACTIVE_W-1:0]     cfg_wdata
);
    import lkoc_pkg::*;

    localparam int RES_W = HANDLE_W + SLOT_W;

    logic [ACTIVE_W-1:0] active_reg;
    lkoc_item_t          item_in;
    lkoc_item_t          item_q;
    logic                item_valid;
    logic                item_take;
    logic [RES_W-1:0]    result_data;
    logic                result_hit;
    logic                result_evicted;

    // active entry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_wdata;
        end
    end

    // unpack the input stream
    always_comb
    begin
        item_in.func   = lkoc_op_t'(s_tuser[0]);
        item_in.key    = s_tdata[KEY_W-1:0];
        item_in.handle = s_tdata[KEY_W+HANDLE_W-1:KEY_W];
    end

    lkoc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_out   (item_q),
        .item_take  (item_take)
    );

    lkoc_engine #(.ENTRIES(ENTRIES)) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item_q),
        .item_take      (item_take),
        .active_entries (active_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .result_data    (result_data),
        .result_hit     (result_hit),
        .result_evicted (result_evicted)
    );

    assign m_tdata = {{(40 - RES_W){1'b0}}, result_data};
    assign m_tuser = {result_evicted, result_hit};

endmodule

>>> hdl/lkoc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are not reset.
module lkoc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/lkoc_queue.sv
// Front end: two-entry request queue between the input stream and the engine.
// Depends on lkoc_pkg for the request struct.
module lkoc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lkoc_pkg::lkoc_item_t item_in,
    output logic                item_valid,
    output lkoc_pkg::lkoc_item_t item_out,
    input  logic                item_take
);
    import lkoc_pkg::*;

    localparam int DEPTH = 2;

    lkoc_item_t       slot_reg [DEPTH];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    assign s_tready   = (count_reg != 2'(DEPTH));
    assign item_valid = (count_reg != 2'd0);
    assign item_out   = slot_reg[rptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_take && item_valid;

    // pointer and occupancy update
    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= item_in;
        end
    end

endmodule

>>> hdl/lkoc_engine.sv
// Back end: scans the entry RAMs one entry a cycle (appends and lookups on an empty cache skip
// the scan), writes back and holds the result. Depends on lkoc_pkg and lkoc_ram.
module lkoc_engine #(
    parameter int ENTRIES = lkoc_pkg::ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  lkoc_pkg::lkoc_item_t              item,
    output logic                              item_take,
    input  logic [lkoc_pkg::ACTIVE_W-1:0]     active_entries,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lkoc_pkg::HANDLE_W+lkoc_pkg::SLOT_W-1:0] result_data,
    output logic                              result_hit,
    output logic                              result_evicted
);
    import lkoc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    lkoc_state_t          state_reg, state_next;
    lkoc_op_t             func_reg, func_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [HANDLE_W-1:0]  hin_reg, hin_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic [IDX_W-1:0]     victim_reg, victim_next;
    logic [STAMP_W-1:0]   min_reg, min_next;
    logic                 hit_reg, hit_next;
    logic                 evict_reg, evict_next;
    logic                 wr_kv_reg, wr_kv_next;
    logic                 wr_stamp_reg, wr_stamp_next;
    logic [HANDLE_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [STAMP_W-1:0]   ctr_reg, ctr_next;
    logic                 ov_reg, ov_next;
    logic [HANDLE_W-1:0]  oh_reg, oh_next;
    logic [SLOT_W-1:0]    os_reg, os_next;
    logic                 ohit_reg, ohit_next;
    logic                 oev_reg, oev_next;

    logic                 start;
    logic                 scan_done;
    logic [CMP_W-1:0]     act_ext;
    logic [CNT_W-1:0]     limit;
    logic [STAMP_W-1:0]   ctr_inc;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_W-1:0]     key_q;
    logic [HANDLE_W-1:0]  handle_q;
    logic [STAMP_W-1:0]   stamp_q;
    logic [IDX_W+SLOT_W-1:0] victim_ext;

    // entry storage, contents undefined until written (fill count guards reads)
    lkoc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (state_reg == ST_WRITE && wr_kv_reg),
        .waddr (victim_reg),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (key_q)
    );

    lkoc_ram #(.WIDTH(HANDLE_W), .DEPTH(ENTRIES)) u_handle_ram (
        .clk   (clk),
        .we    (state_reg == ST_WRITE && wr_kv_reg),
        .waddr (victim_reg),
        .wdata (hin_reg),
        .raddr (rd_addr),
        .rdata (handle_q)
    );

    lkoc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .clk   (clk),
        .we    (state_reg == ST_WRITE && wr_stamp_reg),
        .waddr (victim_reg),
        .wdata (ctr_inc),
        .raddr (rd_addr),
        .rdata (stamp_q)
    );

    // active entry limit clamped to 1..ENTRIES
    always_comb
    begin
        act_ext = CMP_W'(active_entries);
        if (act_ext == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (act_ext > CMP_W'(ENTRIES))
        begin
            limit = CNT_W'(ENTRIES);
        end
        else
        begin
            limit = act_ext[CNT_W-1:0];
        end
    end

    assign ctr_inc   = (ctr_reg == STAMP_MAX) ? STAMP_MAX : ctr_reg + STAMP_W'(1);
    assign rd_addr   = issue_reg[IDX_W-1:0];
    assign start     = item_valid && (!ov_reg || m_tready);
    assign scan_done = !pend_reg && (issue_reg == len_reg);
    assign victim_ext = {{SLOT_W{1'b0}}, victim_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.func == OP_INSERT)
                    begin
                        state_next = (fill_reg < limit) ? ST_WRITE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = (fill_reg == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && func_reg == OP_LOOKUP && key_q == key_reg)
                begin
                    state_next = ST_WRITE;
                end
                else if (scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_take     = 1'b0;
        func_next     = func_reg;
        key_next      = key_reg;
        hin_next      = hin_reg;
        len_next      = len_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        victim_next   = victim_reg;
        min_next      = min_reg;
        hit_next      = hit_reg;
        evict_next    = evict_reg;
        wr_kv_next    = wr_kv_reg;
        wr_stamp_next = wr_stamp_reg;
        found_next    = found_reg;
        fill_next     = fill_reg;
        ctr_next      = ctr_reg;
        ov_next       = (ov_reg && m_tready) ? 1'b0 : ov_reg;
        oh_next       = oh_reg;
        os_next       = os_reg;
        ohit_next     = ohit_reg;
        oev_next      = oev_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_take   = 1'b1;
                    func_next   = item.func;
                    key_next    = item.key;
                    hin_next    = item.handle;
                    issue_next  = '0;
                    victim_next = '0;
                    hit_next    = 1'b0;
                    found_next  = '0;
                    if (item.func == OP_INSERT)
                    begin
                        wr_kv_next    = 1'b1;
                        wr_stamp_next = 1'b1;
                        len_next      = limit;
                        if (fill_reg < limit)
                        begin
                            // append into the next free entry
                            victim_next = fill_reg[IDX_W-1:0];
                            evict_next  = 1'b0;
                            fill_next   = fill_reg + CNT_W'(1);
                        end
                        else
                        begin
                            evict_next = 1'b1;
                        end
                    end
                    else
                    begin
                        wr_kv_next    = 1'b0;
                        wr_stamp_next = 1'b0;
                        evict_next    = 1'b0;
                        len_next      = fill_reg;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read a cycle
                if (issue_reg != len_reg)
                begin
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + CNT_W'(1);
                end
                // evaluate the entry read last cycle
                if (pend_reg)
                begin
                    if (func_reg == OP_LOOKUP)
                    begin
                        if (key_q == key_reg)
                        begin
                            hit_next      = 1'b1;
                            victim_next   = pidx_reg;
                            found_next    = handle_q;
                            wr_stamp_next = 1'b1;
                        end
                    end
                    else if (pidx_reg == '0 || stamp_q < min_reg)
                    begin
                        min_next    = stamp_q;
                        victim_next = pidx_reg;
                    end
                end
            end
            ST_WRITE:
            begin
                if (wr_stamp_reg)
                begin
                    ctr_next = ctr_inc;
                end
                ov_next   = 1'b1;
                oh_next   = found_reg;
                os_next   = victim_ext[SLOT_W-1:0];
                ohit_next = hit_reg;
                oev_next  = evict_reg;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            fill_reg  <= '0;
            ctr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            fill_reg  <= fill_next;
            ctr_reg   <= ctr_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        hin_reg      <= hin_next;
        len_reg      <= len_next;
        issue_reg    <= issue_next;
        pidx_reg     <= pidx_next;
        victim_reg   <= victim_next;
        min_reg      <= min_next;
        hit_reg      <= hit_next;
        evict_reg    <= evict_next;
        wr_kv_reg    <= wr_kv_next;
        wr_stamp_reg <= wr_stamp_next;
        found_reg    <= found_next;
        oh_reg       <= oh_next;
        os_reg       <= os_next;
        ohit_reg     <= ohit_next;
        oev_reg      <= oev_next;
    end

    assign m_tvalid       = ov_reg;
    assign result_data    = {os_reg, oh_reg};
    assign result_hit     = ohit_reg;
    assign result_evicted = oev_reg;

`ifndef SYNTH
    // fill count never passes the entry count
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond entry count");

    // result register is free whenever a result is loaded
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> !ov_reg)
        else $error("result loaded over a pending result");

    // a lookup hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !(ohit_reg && oev_reg))
        else $error("hit and evicted both set");

    // access counter never goes backward across a write-back
    a_ctr_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |=> ctr_reg >= $past(ctr_reg))
        else $error("access counter decreased");

    // scan never issues past its length
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> issue_reg <= len_reg)
        else $error("scan read issued beyond range");
`endif

endmodule
